FILE: design/lwgc_pkg.sv
package lwgc_pkg;

  localparam int LEVEL_W = 16;
  localparam int STEP_W  = 8;
  localparam int INDEX_W = 8;
  localparam int GAIN_W  = 21;
  localparam int DVD_W   = 24;

  localparam logic [LEVEL_W-1:0] TARGET_RESET = 16'd32768;
  localparam logic [STEP_W-1:0]  GSTEP_RESET  = 8'd1;

  localparam int GAIN_MIN = -1048576;
  localparam int GAIN_MAX = 1048575;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  localparam logic REG_TARGET_LEVEL = 1'b0;
  localparam logic REG_GAIN_STEP    = 1'b1;

  // numerator used when a zero entry is loaded
  localparam logic [DVD_W-1:0] ZERO_ENTRY_NUM = 24'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD_DIV,
    S_RD,
    S_EVAL,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic tbl_write_val;
    logic load_div_start;
    logic tbl_write_quo;
    logic walk_step;
    logic set_cap;
    logic mul;
    logic rem_div_start;
    logic rem_add;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic is_compute;
    logic val_zero;
    logic walk_more;
    logic steps_full;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

FILE: design/lwgc_in_if.sv
interface lwgc_in_if;
  import lwgc_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] entry_index;
  logic [LEVEL_W-1:0] entry_value;
  logic [LEVEL_W-1:0] measured_level;

  modport source (output valid, kind, entry_index, entry_value, measured_level, input ready);
  modport sink   (input valid, kind, entry_index, entry_value, measured_level, output ready);
endinterface

FILE: design/lwgc_out_if.sv
interface lwgc_out_if;
  import lwgc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [GAIN_W-1:0] gain_change;
  logic                     step_cap_hit;

  modport source (output valid, gain_change, step_cap_hit, input ready);
  modport sink   (input valid, gain_change, step_cap_hit, output ready);
endinterface

FILE: design/lwgc_div.sv
module lwgc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lwgc_pkg::DVD_W-1:0]   dividend,
  input  logic [lwgc_pkg::LEVEL_W-1:0] divisor,
  output logic                         done,
  output logic [lwgc_pkg::DVD_W-1:0]   quotient
);
  import lwgc_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic [LEVEL_W-1:0] rem;
  logic [LEVEL_W-1:0] dvs;
  logic [DVD_W-1:0]   quo;
  logic [LEVEL_W:0]   rem_sh;
  logic               ge;

  // one quotient bit per cycle, restoring form
  assign rem_sh   = {rem, quo[DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dvs}) && (dvs != '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? LEVEL_W'(rem_sh - {1'b0, dvs}) : LEVEL_W'(rem_sh);
    end
  end

endmodule

FILE: design/lwgc_dp.sv
module lwgc_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_STEPS   = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [lwgc_pkg::LEVEL_W-1:0]        cfg_data,
  input  logic                                in_kind,
  input  logic [lwgc_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic [lwgc_pkg::LEVEL_W-1:0]        in_entry_value,
  input  logic [lwgc_pkg::LEVEL_W-1:0]        in_measured_level,
  input  lwgc_pkg::ctrl_t                     cmd,
  output lwgc_pkg::stat_t                     stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [lwgc_pkg::GAIN_W-1:0]  out_gain_change,
  output logic                                out_step_cap_hit
);
  import lwgc_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int GA  = SW + STEP_W + 1;
  localparam int GW  = ((GA > DVD_W + 1) ? GA : DVD_W + 1) + 1;
  localparam logic signed [GW-1:0] SAT_HI = GW'(GAIN_MAX);
  localparam logic signed [GW-1:0] SAT_LO = GW'(GAIN_MIN);

  logic [LEVEL_W-1:0]       target;
  logic [STEP_W-1:0]        gstep;
  logic                     kind;
  logic [INDEX_W-1:0]       idx;
  logic [LEVEL_W-1:0]       value;
  logic [LEVEL_W-1:0]       level;
  logic                     up;
  logic [SW-1:0]            steps;
  logic signed [GW-1:0]     gain;
  logic                     capped;
  logic [DVD_W-1:0]         product;
  logic [LEVEL_W-1:0]       rd_data;
  logic [LEVEL_W-1:0]       tbl [TABLE_DEPTH];

  logic [LEVEL_W:0]         rnd_sum;
  logic [LEVEL_W-INDEX_W:0] rnd;
  logic [AW-1:0]            rd_addr;
  logic                     idx_ok;
  logic                     tbl_we;
  logic [LEVEL_W-1:0]       wr_data;
  logic [LEVEL_W-1:0]       diff_mag;
  logic                     walk_more;
  logic signed [GW-1:0]     gain_sat;
  logic                     div_start;
  logic [DVD_W-1:0]         div_dvd;
  logic [LEVEL_W-1:0]       div_dvs;
  logic                     div_done;
  logic [DVD_W-1:0]         quo;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
      gstep  <= GSTEP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET_LEVEL: target <= cfg_data;
        REG_GAIN_STEP:    gstep  <= cfg_data[STEP_W-1:0];
        default:          ;
      endcase
    end
  end

  // table index: rounded brightness, saturated at the last entry
  assign rnd_sum = {1'b0, level} + (LEVEL_W+1)'(128);
  assign rnd     = rnd_sum[LEVEL_W:INDEX_W];
  assign rd_addr = (32'(rnd) > 32'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : AW'(rnd);

  assign idx_ok  = 32'(idx) < 32'(TABLE_DEPTH);
  assign tbl_we  = (cmd.tbl_write_val || cmd.tbl_write_quo) && idx_ok;
  assign wr_data = cmd.tbl_write_quo ? quo[LEVEL_W-1:0] : value;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[AW'(idx)] <= wr_data;
    end
    rd_data <= tbl[rd_addr];
  end

  // walk condition, down side written as level > target + entry
  always_comb begin
    if (up) begin
      walk_more = ({1'b0, level} + {1'b0, rd_data}) < {1'b0, target};
    end else begin
      walk_more = {1'b0, level} > ({1'b0, target} + {1'b0, rd_data});
    end
  end

  assign diff_mag = up ? (target - level) : (level - target);

  assign div_start = cmd.load_div_start || cmd.rem_div_start;
  assign div_dvd   = cmd.load_div_start ? ZERO_ENTRY_NUM : product;
  assign div_dvs   = cmd.load_div_start ?
                     ((gstep == '0) ? LEVEL_W'(1) : LEVEL_W'(gstep)) : rd_data;

  lwgc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind   <= in_kind;
      idx    <= in_entry_index;
      value  <= in_entry_value;
      level  <= in_measured_level;
      up     <= in_measured_level < target;
      steps  <= '0;
      gain   <= '0;
      capped <= 1'b0;
    end else begin
      if (cmd.walk_step) begin
        steps <= steps + 1'b1;
        if (up) begin
          level <= level + rd_data;
          gain  <= gain + GW'(gstep);
        end else begin
          level <= level - rd_data;
          gain  <= gain - GW'(gstep);
        end
      end
      if (cmd.set_cap) begin
        capped <= 1'b1;
      end
      if (cmd.mul) begin
        product <= DVD_W'(diff_mag) * DVD_W'(gstep);
      end
      if (cmd.rem_add) begin
        gain <= up ? (gain + GW'(quo)) : (gain - GW'(quo));
      end
    end
  end

  always_comb begin
    if (gain > SAT_HI) begin
      gain_sat = SAT_HI;
    end else if (gain < SAT_LO) begin
      gain_sat = SAT_LO;
    end else begin
      gain_sat = gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gain_change  <= gain_sat[GAIN_W-1:0];
      out_step_cap_hit <= capped;
    end
  end

  always_comb begin
    stat.is_compute = kind == KIND_COMPUTE;
    stat.val_zero   = value == '0;
    stat.walk_more  = walk_more;
    stat.steps_full = steps == SW'(MAX_STEPS);
    stat.div_done   = div_done;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: design/lwgc_ctrl.sv
module lwgc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lwgc_pkg::stat_t stat,
  output lwgc_pkg::ctrl_t cmd
);
  import lwgc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_compute) begin
          state_next = S_RD;
        end else if (stat.val_zero) begin
          cmd.load_div_start = 1'b1;
          state_next         = S_LOAD_DIV;
        end else begin
          cmd.tbl_write_val = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_LOAD_DIV: begin
        if (stat.div_done) begin
          cmd.tbl_write_quo = 1'b1;
          state_next        = S_IDLE;
        end
      end
      // table read of the current level lands at the end of this cycle
      S_RD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.walk_more) begin
          if (stat.steps_full) begin
            cmd.set_cap = 1'b1;
            state_next  = S_DONE;
          end else begin
            cmd.walk_step = 1'b1;
            state_next    = S_RD;
          end
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.rem_div_start = 1'b1;
        state_next        = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.rem_add = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/lut_walk_gain_correction_top.sv
// Gain correction by walking a brightness-step table. Load transactions (kind 0) fill the
// table; a zero value is replaced by 256/gain_step (gain_step 0 counts as 1). Compute
// transactions (kind 1) walk from the measured level toward target_level one table step
// at a time and return one signed gain change plus a flag when MAX_STEPS stopped the walk.
// Items are handled one at a time: a zero load waits on the bit-serial 24-bit divider, and
// a compute is paced by the registered table read in each walk step and by the divider
// that forms the final remainder. The result sits in an output register, so the next item
// is taken while it waits. Table entries that were never loaded hold no defined value.
module lut_walk_gain_correction_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_STEPS   = 4096
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_wr_en,
  input logic                         cfg_index,
  input logic [lwgc_pkg::LEVEL_W-1:0] cfg_data,
  lwgc_in_if.sink                     in_ch,
  lwgc_out_if.source                  out_ch
);
  import lwgc_pkg::*;

  ctrl_t cmd;
  stat_t stat;

  lwgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lwgc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_STEPS   (MAX_STEPS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_ch.kind),
    .in_entry_index    (in_ch.entry_index),
    .in_entry_value    (in_ch.entry_value),
    .in_measured_level (in_ch.measured_level),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_gain_change   (out_ch.gain_change),
    .out_step_cap_hit  (out_ch.step_cap_hit)
  );

endmodule

FILE: design/lwgc_checker.sv
module lwgc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lwgc_pkg::GAIN_W-1:0] gain_change,
  input logic                               step_cap_hit
);

  // one item at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transaction");

  // a result never appears in the cycle after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after a transaction");

  // a result only appears once the block has gone busy
  a_result_needs_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(gain_change) && $stable(step_cap_hit)))
    else $error("stalled result changed");

endmodule

bind lut_walk_gain_correction_top lwgc_checker u_lwgc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .gain_change  (out_ch.gain_change),
  .step_cap_hit (out_ch.step_cap_hit)
);
